>>> hdl/streaming_peak_detector_macros.svh
// Assertion helpers shared by the peak detector modules.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef STREAMING_PEAK_DETECTOR_MACROS_SVH
`define STREAMING_PEAK_DETECTOR_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/spd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

  localparam int unsigned X_W    = 32;
  localparam int unsigned Y_W    = 32;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned HIST_W = X_W + Y_W;

  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic CFG_INVERT_SEARCH = 1'b0;
  localparam logic CFG_ALLOW_BORDER  = 1'b1;

  typedef enum logic [1:0] {
    ST_PEAK  = 2'd0,
    ST_LOST  = 2'd1,
    ST_SHORT = 2'd2,
    ST_END   = 2'd3
  } status_e;

  // Results planned for one sample. Mask bit 0 is the first border or interior
  // peak, bit 1 the closing border peak, bit 2 the end or short-curve marker.
  typedef struct packed {
    logic [2:0]       mask;
    logic [IDX_W-1:0] idx0;
    logic             lost0;
    logic [IDX_W-1:0] idx1;
    logic             lost1;
    logic             byp1;
    logic             short_curve;
    logic [IDX_W-1:0] idx_end;
  } plan_t;

endpackage

`default_nettype wire

>>> hdl/spd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module spd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/spd_track.sv
`timescale 1ns / 1ps
`default_nettype none
`include "streaming_peak_detector_macros.svh"

module spd_track #(
  parameter int unsigned MAX_SAMPLES   = 65536,
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                step_i,
  input  wire logic signed [spd_pkg::Y_W-1:0]      y_i,
  input  wire logic                                last_i,
  input  wire logic                                invert_i,
  input  wire logic                                border_i,
  output spd_pkg::plan_t                           plan_o,
  output logic signed      [spd_pkg::Y_W-1:0]      y_eff_o,
  output logic             [$clog2(HISTORY_DEPTH)-1:0] wr_addr_o,
  output logic             [$clog2(HISTORY_DEPTH)-1:0] rd_addr0_o,
  output logic             [$clog2(HISTORY_DEPTH)-1:0] rd_addr1_o
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES);
  localparam int unsigned FW = CW + 1;
  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [CW-1:0] K_LAST  = CW'(MAX_SAMPLES - 1);
  localparam logic [AW-1:0] DEPTH_A = AW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [31:0]   DEPTH_L = 32'(HISTORY_DEPTH);

  // Ring slot of a sample that lies offs entries behind the write slot.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] wp,
                                               input logic [AW-1:0] offs);
    logic [AW-1:0] addr;
    if (wp >= offs) begin
      addr = wp - offs;
    end else begin
      addr = wp + DEPTH_A - offs;
    end
    return addr;
  endfunction

  logic signed [spd_pkg::Y_W-1:0] y_before_q, y_current_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] flat_q;
  logic          plat_q;
  logic [AW-1:0] wptr_q;

  logic          last, ge2, at2;
  logic          a_gt_b, a_lt_b, a_eq_b, b_gt_c, b_lt_c, b_eq_c;
  logic [FW-1:0] fr1, fr2, fr_pk, run;
  logic          po1, po2;
  logic          first_pk, int_pk, end_pk;
  logic [FW-1:0] int_idx_w, end_idx_w;
  logic [CW-1:0] idx0, idx1, dist0, dist1;

  assign y_eff_o = invert_i ? ((y_i == spd_pkg::Y_MIN) ? spd_pkg::Y_MAX : -y_i) : y_i;

  assign last = last_i || (count_q == K_LAST);
  assign ge2  = count_q >= CW'(2);
  assign at2  = count_q == CW'(2);

  assign a_gt_b = y_before_q > y_current_q;
  assign a_lt_b = y_before_q < y_current_q;
  assign a_eq_b = y_before_q == y_current_q;
  assign b_gt_c = y_current_q > y_eff_o;
  assign b_lt_c = y_current_q < y_eff_o;
  assign b_eq_c = y_current_q == y_eff_o;

  always_comb begin
    fr1      = {1'b0, flat_q};
    po1      = plat_q;
    first_pk = 1'b0;
    if (at2 && border_i) begin
      if (a_gt_b) begin
        first_pk = 1'b1;
      end else if (a_eq_b) begin
        po1 = 1'b1;
        fr1 = fr1 + FW'(1);
      end
    end

    fr2       = fr1;
    po2       = po1;
    int_pk    = 1'b0;
    fr_pk     = fr1 + FW'(1);
    int_idx_w = {1'b0, count_q} - FW'(1);
    if (ge2) begin
      if (a_lt_b && b_gt_c) begin
        int_pk = 1'b1;
      end else if (a_lt_b && b_eq_c) begin
        po2 = 1'b1;
        fr2 = fr1 + FW'(1);
      end else if (a_eq_b) begin
        if (po1 && b_gt_c) begin
          // Flat top: centre of the run, counted back from the sample before.
          int_pk    = 1'b1;
          int_idx_w = {1'b0, count_q} - FW'(1) - (fr_pk >> 1);
          po2       = 1'b0;
          fr2       = '0;
        end else if (b_lt_c) begin
          po2 = 1'b0;
          fr2 = '0;
        end else begin
          fr2 = fr1 + FW'(1);
        end
      end
    end

    run       = fr2 + FW'(po2);
    end_idx_w = {1'b0, count_q} - (run >> 1);
    end_pk    = ge2 && last && border_i && !b_gt_c;
  end

  assign idx0  = first_pk ? '0 : int_idx_w[CW-1:0];
  assign idx1  = end_idx_w[CW-1:0];
  assign dist0 = count_q - idx0;
  assign dist1 = count_q - idx1;

  always_comb begin
    plan_o             = '0;
    plan_o.mask        = {last, end_pk, first_pk | int_pk};
    plan_o.idx0        = spd_pkg::IDX_W'(idx0);
    plan_o.lost0       = 32'(dist0) >= DEPTH_L;
    plan_o.idx1        = spd_pkg::IDX_W'(idx1);
    plan_o.lost1       = 32'(dist1) >= DEPTH_L;
    plan_o.byp1        = dist1 == '0;
    plan_o.short_curve = !ge2;
    plan_o.idx_end     = spd_pkg::IDX_W'(count_q);
  end

  assign wr_addr_o  = wptr_q;
  assign rd_addr0_o = ring_addr(wptr_q, AW'(dist0));
  assign rd_addr1_o = ring_addr(wptr_q, AW'(dist1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_before_q  <= '0;
      y_current_q <= '0;
      count_q     <= '0;
      flat_q      <= '0;
      plat_q      <= 1'b0;
      wptr_q      <= '0;
    end else if (step_i) begin
      if (last) begin
        y_before_q  <= '0;
        y_current_q <= '0;
        count_q     <= '0;
        flat_q      <= '0;
        plat_q      <= 1'b0;
        wptr_q      <= '0;
      end else begin
        y_before_q  <= y_current_q;
        y_current_q <= y_eff_o;
        count_q     <= count_q + CW'(1);
        flat_q      <= fr2[CW-1:0];
        plat_q      <= po2;
        wptr_q      <= (wptr_q == WP_LAST) ? '0 : wptr_q + AW'(1);
      end
    end
  end

  `SPD_ASSERT(a_short_flat, (count_q < CW'(2)) |-> (flat_q == '0 && !plat_q), "flat run set before third sample")
  `SPD_ASSERT_NEXT(a_curve_close, (step_i && last), (count_q == '0 && wptr_q == '0), "curve state not cleared after last sample")

endmodule

`default_nettype wire

>>> hdl/spd_drain.sv
`timescale 1ns / 1ps
`default_nettype none
`include "streaming_peak_detector_macros.svh"

module spd_drain (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              load_i,
  input  spd_pkg::plan_t                         plan_i,
  input  wire logic        [spd_pkg::X_W-1:0]    byp_x_i,
  input  wire logic signed [spd_pkg::Y_W-1:0]    byp_y_i,
  input  wire logic        [spd_pkg::HIST_W-1:0] rdata0_i,
  input  wire logic        [spd_pkg::HIST_W-1:0] rdata1_i,
  output logic                                   free_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic             [1:0]                 status_o,
  output logic             [spd_pkg::IDX_W-1:0]  peak_index_o,
  output logic             [spd_pkg::X_W-1:0]    peak_x_o,
  output logic signed      [spd_pkg::Y_W-1:0]    peak_y_o,
  output logic                                   run_last_o
);

  logic [2:0]                     mask_q;
  spd_pkg::plan_t                 plan_q;
  logic [spd_pkg::X_W-1:0]        byp_x_q;
  logic signed [spd_pkg::Y_W-1:0] byp_y_q;

  logic                           c_valid_q;
  spd_pkg::status_e               c_status_q, st_d;
  logic [spd_pkg::IDX_W-1:0]      c_idx_q, idx_d;
  logic [spd_pkg::X_W-1:0]        c_x_q, x_d;
  logic signed [spd_pkg::Y_W-1:0] c_y_q, y_d;
  logic                           c_last_q;

  logic [2:0] rest;
  logic       c_ready, take;

  assign rest    = mask_q & (mask_q - 3'd1);
  assign c_ready = !c_valid_q || !out_stall_i;
  assign take    = (mask_q != 3'd0) && c_ready;
  assign free_o  = (mask_q == 3'd0) || (c_ready && rest == 3'd0);

  always_comb begin
    st_d  = plan_q.short_curve ? spd_pkg::ST_SHORT : spd_pkg::ST_END;
    idx_d = plan_q.idx_end;
    x_d   = '0;
    y_d   = '0;
    if (mask_q[0]) begin
      idx_d = plan_q.idx0;
      if (plan_q.lost0) begin
        st_d = spd_pkg::ST_LOST;
      end else begin
        st_d = spd_pkg::ST_PEAK;
        x_d  = rdata0_i[spd_pkg::X_W-1:0];
        y_d  = rdata0_i[spd_pkg::HIST_W-1:spd_pkg::X_W];
      end
    end else if (mask_q[1]) begin
      idx_d = plan_q.idx1;
      if (plan_q.lost1) begin
        st_d = spd_pkg::ST_LOST;
      end else if (plan_q.byp1) begin
        // The peak is the sample just written, so take it straight from the input side.
        st_d = spd_pkg::ST_PEAK;
        x_d  = byp_x_q;
        y_d  = byp_y_q;
      end else begin
        st_d = spd_pkg::ST_PEAK;
        x_d  = rdata1_i[spd_pkg::X_W-1:0];
        y_d  = rdata1_i[spd_pkg::HIST_W-1:spd_pkg::X_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= 3'd0;
      c_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        mask_q <= plan_i.mask;
      end else if (take) begin
        mask_q <= rest;
      end
      if (take) begin
        c_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        c_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      plan_q  <= plan_i;
      byp_x_q <= byp_x_i;
      byp_y_q <= byp_y_i;
    end
    if (take) begin
      c_status_q <= st_d;
      c_idx_q    <= idx_d;
      c_x_q      <= x_d;
      c_y_q      <= y_d;
      c_last_q   <= rest == 3'd0;
    end
  end

  assign out_valid_o  = c_valid_q;
  assign status_o     = c_status_q;
  assign peak_index_o = c_idx_q;
  assign peak_x_o     = c_x_q;
  assign peak_y_o     = c_y_q;
  assign run_last_o   = c_last_q;

  `SPD_ASSERT(a_hold_bundle, (rest != 3'd0) |-> !free_o, "bundle released with results pending")
  `SPD_ASSERT(a_lost_zero, (out_valid_o && status_o == spd_pkg::ST_LOST) |-> (peak_x_o == '0 && peak_y_o == '0), "lost peak carries data")

endmodule

`default_nettype wire

>>> hdl/streaming_peak_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming peak detector: one curve sample (x, y, last flag) per input transfer,
// zero to three results per sample on the output channel (peaks, then the end
// or short-curve marker on the last sample, with run_last on the final one).
// Both channels use valid/stall; a transfer happens when valid is high and stall
// is low. Configuration (invert_search, allow_border) is written through a
// simple write port while the block is idle.
// A sample's first result passes through the input register, the decision
// stage with its history read, and the output register.
// Throughput: one sample per cycle if each sample gives at most one result and
// the output is not stalled; a sample with n results holds the decision stage
// for n output transfers, the output register draining one per unstalled cycle.
// The x/y history is a ring of HISTORY_DEPTH entries in a RAM with one write and
// two registered read ports; it is not cleared, only entries of the current
// curve are ever read. Reset clears the curve state, configuration and flags.
// When the receiver stalls, the output register holds, the decision stage fills
// and in_stall_o rises once the input register is occupied.

module streaming_peak_detector #(
  parameter int unsigned MAX_SAMPLES   = 65536,
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_index_i,
  input  wire logic                             cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic        [spd_pkg::X_W-1:0]   x_value_i,
  input  wire logic signed [spd_pkg::Y_W-1:0]   y_value_i,
  input  wire logic                             is_last_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic             [1:0]                status_o,
  output logic             [spd_pkg::IDX_W-1:0] peak_index_o,
  output logic             [spd_pkg::X_W-1:0]   peak_x_o,
  output logic signed      [spd_pkg::Y_W-1:0]   peak_y_o,
  output logic                                  run_last_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic invert_q, border_q;

  // Input register: one sample waiting for the decision stage.
  logic                           a_valid_q;
  logic [spd_pkg::X_W-1:0]        a_x_q;
  logic signed [spd_pkg::Y_W-1:0] a_y_q;
  logic                           a_last_q;

  logic accept, step, b_free;

  spd_pkg::plan_t                 plan;
  logic signed [spd_pkg::Y_W-1:0] y_eff;
  logic [AW-1:0]                  wr_addr, rd_addr0, rd_addr1;
  logic [spd_pkg::HIST_W-1:0]     rdata0, rdata1;

  // User issues configuration writes only with no transfer in flight; unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      border_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spd_pkg::CFG_INVERT_SEARCH: invert_q <= cfg_data_i;
        spd_pkg::CFG_ALLOW_BORDER:  border_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A sample moves on into the decision stage as soon as that stage is free,
  // so the input register takes a new transfer in the same cycle.
  assign step       = a_valid_q && b_free;
  assign in_stall_o = a_valid_q && !b_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (step) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_x_q    <= x_value_i;
      a_y_q    <= y_value_i;
      a_last_q <= is_last_i;
    end
  end

  // Curve state and peak decisions; the current sample is written to the ring
  // in the same cycle as the peak samples are read.
  spd_track #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .y_i       (a_y_q),
    .last_i    (a_last_q),
    .invert_i  (invert_q),
    .border_i  (border_q),
    .plan_o    (plan),
    .y_eff_o   (y_eff),
    .wr_addr_o (wr_addr),
    .rd_addr0_o(rd_addr0),
    .rd_addr1_o(rd_addr1)
  );

  spd_ram #(
    .WIDTH(spd_pkg::HIST_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (wr_addr),
    .wdata_i ({y_eff, a_x_q}),
    .re_i    (step),
    .raddr0_i(rd_addr0),
    .raddr1_i(rd_addr1),
    .rdata0_o(rdata0),
    .rdata1_o(rdata1)
  );

  // Decision stage and output register: results leave one per transfer.
  spd_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .plan_i      (plan),
    .byp_x_i     (a_x_q),
    .byp_y_i     (y_eff),
    .rdata0_i    (rdata0),
    .rdata1_i    (rdata1),
    .free_o      (b_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .peak_index_o(peak_index_o),
    .peak_x_o    (peak_x_o),
    .peak_y_o    (peak_y_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire
